FILE: hdl/tlct_pkg.sv
// Shared types and constants for the text line/column tracker.
// No dependencies; every other file of the block refers to it by scoped name.
`timescale 1ns / 1ps

package tlct_pkg;

  // default position widths
  localparam int LINE_BITS_DEF   = 24;
  localparam int COLUMN_BITS_DEF = 16;

  // configuration widths
  localparam int TAB_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [TAB_W-1:0] TAB_WIDTH_RST = 7'd8;

  // byte codes and class bounds
  localparam logic [7:0] BYTE_LF       = 8'h0A;
  localparam logic [7:0] BYTE_CR       = 8'h0D;
  localparam logic [7:0] BYTE_TAB      = 8'h09;
  localparam logic [7:0] BYTE_SPACE    = 8'h20;
  localparam logic [7:0] BYTE_PRINT_HI = 8'h7E;
  localparam logic [7:0] LEAD2_LO      = 8'hC0;
  localparam logic [7:0] LEAD2_HI      = 8'hDF;
  localparam logic [7:0] LEAD3_LO      = 8'hE0;
  localparam logic [7:0] LEAD3_HI      = 8'hEF;
  localparam logic [7:0] LEAD4_LO      = 8'hF0;
  localparam logic [7:0] LEAD4_HI      = 8'hFF;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_MARK = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAB_WIDTH     = 2'd0,
    REG_TAB_STOP_MODE = 2'd1
  } cfg_reg_t;

  // controller -> datapath
  typedef struct packed {
    logic take_marker;
    logic take_byte;
    logic div_start;
    logic div_step;
    logic div_done;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_div;
  } sts_t;

endpackage

FILE: hdl/tlct_if.sv
// Valid/ready channel interfaces of the tracker: input items, result items
// and configuration writes. Depends on tlct_pkg.
`timescale 1ns / 1ps

interface tlct_in_if;
  logic              valid;
  logic              ready;
  tlct_pkg::opcode_t opcode;
  logic [7:0]        text_byte;

  modport source (output valid, opcode, text_byte, input ready);
  modport sink   (input valid, opcode, text_byte, output ready);
endinterface

interface tlct_out_if #(
  parameter int LINE_BITS   = tlct_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = tlct_pkg::COLUMN_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [LINE_BITS-1:0]   line_number;
  logic [COLUMN_BITS-1:0] column_number;

  modport source (output valid, line_number, column_number, input ready);
  modport sink   (input valid, line_number, column_number, output ready);
endinterface

interface tlct_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tlct_pkg::CFG_IDX_W-1:0]  index;
  logic [tlct_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/tlct_ctrl.sv
// Controller of the tracker: handshakes, sequencing of the serial tab-stop
// remainder and the result-valid flag. Depends on tlct_pkg.
`timescale 1ns / 1ps

module tlct_ctrl #(
  parameter int COLUMN_BITS = tlct_pkg::COLUMN_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  tlct_pkg::opcode_t in_opcode,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tlct_pkg::sts_t    sts,
  output tlct_pkg::cmd_t    cmd
);

  localparam int STEPS = COLUMN_BITS + 1;
  localparam int CNT_W = $clog2(STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  // a byte may go in while a result waits; a marker needs the output slot
  assign in_ready = (state_r == ST_IDLE) &&
                    ((in_opcode == tlct_pkg::OP_BYTE) || !out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.take_marker = accept && (in_opcode == tlct_pkg::OP_MARK);
    cmd.take_byte   = accept && (in_opcode == tlct_pkg::OP_BYTE) && !sts.needs_div;
    cmd.div_start   = accept && (in_opcode == tlct_pkg::OP_BYTE) && sts.needs_div;
    cmd.div_step    = (state_r == ST_DIV);
    cmd.div_done    = (state_r == ST_FIN);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.div_start) begin
          state_nxt = ST_DIV;
          cnt_nxt   = CNT_W'(STEPS - 1);
        end
      end
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FIN: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.take_marker) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/tlct_dp.sv
// Datapath of the tracker: configuration registers, line/column/skip state,
// bit-serial remainder for tab stops and the result registers. Depends on tlct_pkg.
`timescale 1ns / 1ps

module tlct_dp #(
  parameter int LINE_BITS   = tlct_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = tlct_pkg::COLUMN_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  tlct_cfg_if.sink               cfg_ch,
  input  logic [7:0]             in_text_byte,
  input  tlct_pkg::cmd_t         cmd,
  output tlct_pkg::sts_t         sts,
  output logic [LINE_BITS-1:0]   out_line,
  output logic [COLUMN_BITS-1:0] out_column
);

  localparam int NUM_W = COLUMN_BITS + 1;
  localparam int TW    = tlct_pkg::TAB_W;

  logic [TW-1:0]          tab_width_r;
  logic                   tab_stop_mode_r;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;
  logic [1:0]             skip_r, skip_nxt;

  logic [NUM_W-1:0]       num_r, shf_r;
  logic [TW-1:0]          rem_r, rem_step;
  logic [LINE_BITS-1:0]   line_out_r;
  logic [COLUMN_BITS-1:0] col_out_r;

  logic [NUM_W-1:0]       col_ext, col_inc, col_tab, tab_num, stop_col;
  logic [COLUMN_BITS-1:0] col_inc_sat, col_tab_sat, stop_col_sat;
  logic [LINE_BITS-1:0]   line_inc_sat;
  logic [TW:0]            rem_sh;

  assign cfg_ch.ready = 1'b1;
  assign out_line     = line_out_r;
  assign out_column   = col_out_r;

  assign sts.needs_div = (skip_r == 2'd0) && (in_text_byte == tlct_pkg::BYTE_TAB) &&
                         tab_stop_mode_r && (tab_width_r > TW'(1));

  // column arithmetic, one bit of headroom then saturate
  assign col_ext  = {1'b0, col_r};
  assign col_inc  = col_ext + NUM_W'(1);
  assign col_tab  = col_ext + NUM_W'(tab_width_r);
  assign tab_num  = col_tab + NUM_W'(1);
  // floor(n / w) * w == n - (n mod w)
  assign stop_col = num_r - NUM_W'(rem_r);

  assign col_inc_sat  = col_inc[COLUMN_BITS]  ? '1 : col_inc[COLUMN_BITS-1:0];
  assign col_tab_sat  = col_tab[COLUMN_BITS]  ? '1 : col_tab[COLUMN_BITS-1:0];
  assign stop_col_sat = stop_col[COLUMN_BITS] ? '1 : stop_col[COLUMN_BITS-1:0];
  assign line_inc_sat = (line_r == '1) ? line_r : line_r + 1'b1;

  // one restoring-remainder step, MSB of the numerator first
  assign rem_sh   = {rem_r, shf_r[NUM_W-1]};
  assign rem_step = (rem_sh >= {1'b0, tab_width_r}) ? TW'(rem_sh - {1'b0, tab_width_r})
                                                    : rem_sh[TW-1:0];

  // byte decode
  always_comb begin
    line_nxt = line_r;
    col_nxt  = col_r;
    skip_nxt = skip_r;
    if (skip_r != 2'd0) begin
      skip_nxt = skip_r - 2'd1;
    end else begin
      unique case (in_text_byte) inside
        tlct_pkg::BYTE_LF: begin
          line_nxt = line_inc_sat;
          col_nxt  = COLUMN_BITS'(1);
        end
        tlct_pkg::BYTE_TAB: begin
          col_nxt = col_tab_sat;
        end
        [tlct_pkg::BYTE_SPACE:tlct_pkg::BYTE_PRINT_HI]: begin
          col_nxt = col_inc_sat;
        end
        [tlct_pkg::LEAD2_LO:tlct_pkg::LEAD2_HI]: begin
          col_nxt  = col_inc_sat;
          skip_nxt = 2'd1;
        end
        [tlct_pkg::LEAD3_LO:tlct_pkg::LEAD3_HI]: begin
          col_nxt  = col_inc_sat;
          skip_nxt = 2'd2;
        end
        [tlct_pkg::LEAD4_LO:tlct_pkg::LEAD4_HI]: begin
          col_nxt  = col_inc_sat;
          skip_nxt = 2'd3;
        end
        default: begin
          // carriage return, controls, DEL, stray continuation bytes
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_width_r     <= tlct_pkg::TAB_WIDTH_RST;
      tab_stop_mode_r <= 1'b0;
      line_r          <= LINE_BITS'(1);
      col_r           <= COLUMN_BITS'(1);
      skip_r          <= 2'd0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          tlct_pkg::REG_TAB_WIDTH:     tab_width_r     <= cfg_ch.data[TW-1:0];
          tlct_pkg::REG_TAB_STOP_MODE: tab_stop_mode_r <= cfg_ch.data[0];
          default: begin
          end
        endcase
      end
      if (cmd.take_marker) begin
        skip_r <= 2'd0;
      end else if (cmd.take_byte) begin
        line_r <= line_nxt;
        col_r  <= col_nxt;
        skip_r <= skip_nxt;
      end else if (cmd.div_done) begin
        col_r <= stop_col_sat;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_marker) begin
      line_out_r <= line_r;
      col_out_r  <= col_r;
    end
    if (cmd.div_start) begin
      num_r <= tab_num;
      shf_r <= tab_num;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      shf_r <= {shf_r[NUM_W-2:0], 1'b0};
      rem_r <= rem_step;
    end
  end

endmodule

FILE: hdl/text_line_column_tracker.sv
// Text line/column tracker, top level: tlct_ctrl plus tlct_dp on three channels.
// Items go in only when idle, a marker only with the output slot free; a tab in
// tab-stop mode holds the input while the one-bit-per-cycle remainder runs over the
// COLUMN_BITS+1 bit numerator. Markers answer from the result register, next cycle.
// Synchronous active-low reset: line 1, column 1, no pending skip, tab width 8,
// fixed-width tabs, no result pending; no clearing pass.
`timescale 1ns / 1ps

module text_line_column_tracker #(
  parameter int LINE_BITS   = tlct_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = tlct_pkg::COLUMN_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  tlct_in_if.sink    in_ch,
  tlct_out_if.source out_ch,
  tlct_cfg_if.sink   cfg_ch
);

  // command/status pair between the sequencer and the datapath
  tlct_pkg::cmd_t cmd;
  tlct_pkg::sts_t sts;

  logic [LINE_BITS-1:0]   dp_line;
  logic [COLUMN_BITS-1:0] dp_column;

  // Controller: owns in.ready / out.valid and the remainder step counter.
  tlct_ctrl #(
    .COLUMN_BITS (COLUMN_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: position state, config registers and the result item.
  tlct_dp #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_ch       (cfg_ch),
    .in_text_byte (in_ch.text_byte),
    .cmd          (cmd),
    .sts          (sts),
    .out_line     (dp_line),
    .out_column   (dp_column)
  );

  // result payload straight from the datapath's output registers
  assign out_ch.line_number   = dp_line;
  assign out_ch.column_number = dp_column;

endmodule

FILE: tb/tlct_position_checker.sv
`timescale 1ns / 1ps
// Position checker for the text line/column tracker: watches the input, result
// and configuration channels, predicts each marker's location and compares it.
// Depends on tlct_pkg and the channel interfaces of tlct_if.sv.

module tlct_position_checker #(
  parameter int LINE_BITS   = tlct_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = tlct_pkg::COLUMN_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  tlct_in_if   in_mon,
  tlct_out_if  out_mon,
  tlct_cfg_if  cfg_mon,
  output int   mismatches,
  output int   outstanding,
  output int   reports
);
  import tlct_pkg::*;

  localparam longint unsigned COL_TOP = (64'd1 << COLUMN_BITS) - 1;

  typedef struct {
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
  } location_t;

  location_t              expected_locs[$];
  location_t              due;
  logic [LINE_BITS-1:0]   cur_line;
  logic [COLUMN_BITS-1:0] cur_col;
  logic [1:0]             skip_left;
  logic [TAB_W-1:0]       tab_cfg;
  logic                   stop_cfg;

  function automatic logic [COLUMN_BITS-1:0] clamp_col(input longint unsigned v);
    return (v > COL_TOP) ? '1 : v[COLUMN_BITS-1:0];
  endfunction

  // One source byte against the tracked position.
  function automatic void take_text_byte(input logic [7:0] b);
    longint unsigned col;
    longint unsigned tw;
    col = 64'(cur_col);
    tw  = 64'(tab_cfg);
    if (skip_left != 0) begin
      skip_left = skip_left - 1'b1;          // continuation byte, whatever it holds
    end else if (b == BYTE_LF) begin
      if (cur_line != '1) cur_line = cur_line + 1'b1;
      cur_col = COLUMN_BITS'(1);
    end else if (b == BYTE_CR) begin
    end else if (b == BYTE_TAB) begin
      if (stop_cfg && tw > 1) cur_col = clamp_col(((col + tw + 1) / tw) * tw);
      else cur_col = clamp_col(col + tw);
    end else if (b == BYTE_SPACE) begin
      cur_col = clamp_col(col + 1);
    end else if (b >= LEAD4_LO) begin
      cur_col   = clamp_col(col + 1);
      skip_left = 2'd3;
    end else if (b >= LEAD3_LO) begin
      cur_col   = clamp_col(col + 1);
      skip_left = 2'd2;
    end else if (b >= LEAD2_LO) begin
      cur_col   = clamp_col(col + 1);
      skip_left = 2'd1;
    end else if (b > BYTE_SPACE && b <= BYTE_PRINT_HI) begin
      cur_col = clamp_col(col + 1);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_locs.delete();
      cur_line  = LINE_BITS'(1);
      cur_col   = COLUMN_BITS'(1);
      skip_left = '0;
      tab_cfg   = TAB_WIDTH_RST;
      stop_cfg  = 1'b0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_t'(cfg_mon.index))
          REG_TAB_WIDTH:     tab_cfg = cfg_mon.data[TAB_W-1:0];
          REG_TAB_STOP_MODE: stop_cfg = cfg_mon.data[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.opcode == OP_MARK) begin
          skip_left = '0;
          expected_locs.push_back('{cur_line, cur_col});
        end else begin
          take_text_byte(in_mon.text_byte);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        reports++;
        if (expected_locs.size() == 0) begin
          mismatches++;
          $display("%0t: location with no marker pending: expected none, got line %0d column %0d",
                   $time, out_mon.line_number, out_mon.column_number);
        end else begin
          due = expected_locs.pop_front();
          if (out_mon.line_number !== due.line) begin
            mismatches++;
            $display("%0t: line_number mismatch: expected %0d, got %0d",
                     $time, due.line, out_mon.line_number);
          end
          if (out_mon.column_number !== due.column) begin
            mismatches++;
            $display("%0t: column_number mismatch: expected %0d, got %0d",
                     $time, due.column, out_mon.column_number);
          end
        end
      end
    end
    outstanding <= expected_locs.size();
  end

endmodule

FILE: tb/tb_text_line_column_tracker.sv
`timescale 1ns / 1ps
// Testbench top for text_line_column_tracker: clock, reset, stimulus and verdict.
// Depends on tlct_pkg, tlct_if.sv, the block RTL and tlct_position_checker.

module tb_text_line_column_tracker;
  import tlct_pkg::*;

  localparam int CYCLE_LIMIT    = 500000;
  localparam int SETTLE_CYCLES  = COLUMN_BITS_DEF + 8;   // covers a tab-stop division
  localparam int RX_HOLD_CYCLES = 300;
  localparam int IDLE_PCT       = 24;
  localparam int SAT_TABS       = 520;                   // 520 * 127 overruns 16 bits
  localparam int PLAIN_MARK_PCT = 10;
  localparam int DENSE_MARK_PCT = 50;

  // indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_US  = 8'h1F;
  localparam logic [7:0] BYTE_DEL = 8'h7F;
  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [7:0] CONT_LO  = 8'h80;
  localparam logic [7:0] CONT_HI  = 8'hBF;

  logic clk;
  logic rst_n;
  logic calm;       // no idling on either side while high
  logic hold_req;   // rising edge asks the receiver for one long hold-off
  int   items_sent;
  int   settings_used;
  int   cycles;
  int   mismatches;
  int   outstanding;
  int   reports;
  int   hold_left = 0;
  logic hold_seen = 1'b0;

  tlct_in_if  in_ch ();
  tlct_out_if out_ch ();
  tlct_cfg_if cfg_ch ();

  text_line_column_tracker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  tlct_position_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_mon     (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .reports     (reports)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random back-pressure, solid ready while calm, and one long
  // hold-off counted here so the block fills up and stalls its input.
  always @(posedge clk) begin
    if (hold_req && !hold_seen) hold_left = RX_HOLD_CYCLES;
    hold_seen = hold_req;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d locations still due",
               $time, cycles, outstanding);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One item on the input channel, with random idle cycles in front unless calm.
  // valid stays up between back-to-back items.
  task automatic send_item(input opcode_t op, input logic [7:0] b);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.text_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Stop offering, let every location come back, then give any tab-stop
  // division still running time to finish before registers are touched.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Tab width, then a write to an unused index that must not land, then mode.
  // valid stays high across the three writes and drops once at the end.
  task automatic set_tabs(input logic [TAB_W-1:0] width, input logic stop_mode);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_TAB_WIDTH;
    cfg_ch.data  <= CFG_DATA_W'(width);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= ($urandom_range(1) != 0) ? REG_SPARE_HI : REG_SPARE_LO;
    cfg_ch.data  <= CFG_DATA_W'($urandom);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_TAB_STOP_MODE;
    cfg_ch.data  <= CFG_DATA_W'(stop_mode);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  // Lead byte of a UTF-8 sequence with the given number of continuation bytes.
  function automatic logic [7:0] utf8_lead(input int conts);
    case (conts)
      1:       return 8'($urandom_range(LEAD2_HI, LEAD2_LO));
      2:       return 8'($urandom_range(LEAD3_HI, LEAD3_LO));
      default: return 8'($urandom_range(LEAD4_HI, LEAD4_LO));
    endcase
  endfunction

  // Mostly well-formed text: words closed by a boundary marker, blanks, line
  // ends and complete UTF-8 characters. The rest is cut-off UTF-8 (ended by a
  // marker or a newline that must be swallowed), stray markers and raw bytes.
  task automatic random_burst(input int n, input int mark_pct);
    int stop_at;
    int pick;
    int len;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < mark_pct) begin
        send_item(OP_MARK, 8'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          len = $urandom_range(6, 1);
          repeat (len) send_item(OP_BYTE, 8'($urandom_range(BYTE_PRINT_HI, BYTE_SPACE + 1)));
          send_item(OP_MARK, 8'($urandom));
        end else if (pick < 45) begin
          repeat ($urandom_range(3, 1)) begin
            case ($urandom_range(2))
              0:       send_item(OP_BYTE, BYTE_SPACE);
              1:       send_item(OP_BYTE, BYTE_TAB);
              default: send_item(OP_BYTE, BYTE_CR);
            endcase
          end
        end else if (pick < 55) begin
          if ($urandom_range(1) != 0) send_item(OP_BYTE, BYTE_CR);
          send_item(OP_BYTE, BYTE_LF);
        end else if (pick < 72) begin
          len = $urandom_range(3, 1);
          send_item(OP_BYTE, utf8_lead(len));
          repeat (len) send_item(OP_BYTE, 8'($urandom_range(CONT_HI, CONT_LO)));
        end else if (pick < 80) begin
          len = $urandom_range(3, 1);
          send_item(OP_BYTE, utf8_lead(len));
          repeat ($urandom_range(len - 1, 0))
            send_item(OP_BYTE, 8'($urandom_range(CONT_HI, CONT_LO)));
          if ($urandom_range(1) != 0) send_item(OP_MARK, 8'($urandom));
          else send_item(OP_BYTE, BYTE_LF);
        end else begin
          send_item(OP_BYTE, 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_BYTE;
    in_ch.text_byte = BYTE_NUL;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_TAB_WIDTH;
    cfg_ch.data     = '0;
    out_ch.ready    = 1'b0;
    items_sent      = 0;
    settings_used   = 0;
    cycles          = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass at the reset settings (tab 8, fixed width).
    send_item(OP_MARK, BYTE_NUL);       // position straight out of reset
    send_item(OP_BYTE, BYTE_SPACE + 1'b1);
    send_item(OP_BYTE, BYTE_PRINT_HI);
    send_item(OP_BYTE, BYTE_SPACE);
    send_item(OP_BYTE, BYTE_TAB);
    send_item(OP_MARK, LEAD4_HI);       // byte on a marker is don't-care
    send_item(OP_BYTE, BYTE_CR);        // CR, DEL, controls, stray continuations:
    send_item(OP_BYTE, BYTE_DEL);       // none of them moves the column
    send_item(OP_BYTE, BYTE_NUL);
    send_item(OP_BYTE, CONT_LO);
    send_item(OP_BYTE, CONT_HI);
    send_item(OP_BYTE, BYTE_US);
    send_item(OP_MARK, BYTE_NUL);
    send_item(OP_BYTE, BYTE_LF);
    send_item(OP_BYTE, LEAD2_LO);       // two-byte lead, next byte skipped
    send_item(OP_BYTE, CHAR_A);
    send_item(OP_BYTE, LEAD3_HI);       // three-byte lead swallows a newline
    send_item(OP_BYTE, BYTE_LF);
    send_item(OP_BYTE, BYTE_SPACE);
    send_item(OP_BYTE, LEAD4_LO);       // four-byte lead cut short by a marker
    send_item(OP_BYTE, CONT_LO);
    send_item(OP_MARK, BYTE_LF);
    send_item(OP_BYTE, CHAR_A);         // skip must be gone after the marker
    send_item(OP_BYTE, LEAD2_HI);
    send_item(OP_MARK, BYTE_NUL);
    send_item(OP_BYTE, LEAD4_HI);
    send_item(OP_BYTE, LEAD3_LO);       // consumed as a continuation
    send_item(OP_MARK, BYTE_NUL);
    settle();

    // Zero width: tabs do nothing, in either mode.
    set_tabs(7'd0, 1'b1);
    random_burst(70, PLAIN_MARK_PCT);
    settle();

    // Width 1 in stop mode falls back to adding one.
    set_tabs(7'd1, 1'b1);
    random_burst(70, PLAIN_MARK_PCT);
    settle();

    // Narrowest real tab stops, and the stretch with no idling on either side.
    set_tabs(7'd2, 1'b1);
    calm <= 1'b1;
    random_burst(70, PLAIN_MARK_PCT);
    calm <= 1'b0;
    settle();

    // Widest fixed tab: run the column into saturation and past it.
    set_tabs(7'd127, 1'b0);
    send_item(OP_BYTE, BYTE_LF);
    for (int i = 0; i < SAT_TABS; i++) begin
      send_item(OP_BYTE, BYTE_TAB);
      if (i % 128 == 127) send_item(OP_MARK, 8'($urandom));
    end
    send_item(OP_BYTE, CHAR_A);
    send_item(OP_MARK, 8'($urandom));
    settle();

    // Widest tab stop, starting from a saturated column.
    set_tabs(7'd127, 1'b1);
    send_item(OP_BYTE, BYTE_TAB);
    send_item(OP_MARK, 8'($urandom));
    random_burst(60, PLAIN_MARK_PCT);
    settle();

    set_tabs(7'd64, 1'b1);
    random_burst(70, PLAIN_MARK_PCT);
    settle();

    // Marker-heavy traffic against a long output hold-off.
    set_tabs(7'd5, 1'b1);
    hold_req <= 1'b1;
    random_burst(70, DENSE_MARK_PCT);
    hold_req <= 1'b0;
    settle();

    set_tabs(7'd3, 1'b0);
    random_burst(70, PLAIN_MARK_PCT);
    settle();

    $display("Covered %0d items and %0d location reports over %0d tab settings,",
             items_sent, reports, settings_used + 1);
    $display("with tab stops, UTF-8 skips, column saturation and a %0d-cycle output stall.",
             RX_HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
